// ===== design/tpca_pkg.sv =====
// Shared constants, codes and handshake structs for the two-pool chunk allocator.
`timescale 1ns / 1ps
`default_nettype none

package tpca_pkg;

    // Pool geometry
    localparam int SMALL_SLOT_BYTES = 32;
    localparam int LARGE_SLOT_BYTES = 256;
    localparam int SMALL_SLOTS      = 1024;
    localparam int LARGE_SLOTS      = 256;
    localparam int SMALL_LIMIT      = 3 * SMALL_SLOT_BYTES;

    // Field widths
    localparam int BYTES_W     = 16;
    localparam int NEED_W      = 17;
    localparam int FIDX_W      = 10;
    localparam int GIDX_W      = 10;
    localparam int GSLOTS_W    = 11;
    localparam int STATUS_W    = 2;
    localparam int SMALL_LEN_W = $clog2(SMALL_SLOTS + 1);
    localparam int LARGE_LEN_W = $clog2(LARGE_SLOTS + 1);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Pool codes
    localparam logic POOL_SMALL = 1'b0;
    localparam logic POOL_LARGE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTUSED = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [NEED_W-1:0] need;
        logic [FIDX_W-1:0] idx;
    } pool_op_t;

    typedef struct packed {
        logic                done;
        logic                grant;
        logic [STATUS_W-1:0] status;
        logic [GIDX_W-1:0]   index;
        logic [GSLOTS_W-1:0] slots;
    } pool_res_t;

endpackage

`default_nettype wire

// ===== design/tpca_need.sv =====
// Request sizing: picks the pool and the slot count for an allocate beat.
`timescale 1ns / 1ps
`default_nettype none

module tpca_need
    import tpca_pkg::*;
(
    input  wire logic [BYTES_W-1:0] request_bytes,
    output logic                    pool,
    output logic [NEED_W-1:0]       need
);

    localparam int SMALL_SHIFT = $clog2(SMALL_SLOT_BYTES);
    localparam int LARGE_SHIFT = $clog2(LARGE_SLOT_BYTES);

    logic [NEED_W-1:0] padded;

    assign padded = NEED_W'(request_bytes) + NEED_W'(4);

    always_comb
    begin
        if (NEED_W'(request_bytes) > NEED_W'(SMALL_LIMIT))
        begin
            pool = POOL_LARGE;
            need = (padded >> LARGE_SHIFT) + NEED_W'(1);
        end
        else
        begin
            pool = POOL_SMALL;
            need = (padded >> SMALL_SHIFT) + NEED_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== design/tpca_pool.sv =====
// One pool: header memory, rover, in-use count and the walk/merge sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tpca_pool
    import tpca_pkg::*;
#(
    parameter int SLOTS = SMALL_SLOTS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire pool_op_t                     op,
    input  wire logic                         ack,
    output pool_res_t                         res,
    output logic [$clog2(SLOTS + 1)-1:0]      count
);

    localparam int LEN_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int POS_W  = LEN_W + 1;
    localparam int CMP_W  = ((POS_W > NEED_W) ? POS_W : NEED_W) + 1;
    localparam int HDR_W  = LEN_W + 1;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_C  = CMP_W'(SLOTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_AREAD  = 4'd1;
    localparam logic [3:0] S_AEVAL  = 4'd2;
    localparam logic [3:0] S_ASPLIT = 4'd3;
    localparam logic [3:0] S_FREAD  = 4'd4;
    localparam logic [3:0] S_FEVAL  = 4'd5;
    localparam logic [3:0] S_FNEXT  = 4'd6;
    localparam logic [3:0] S_FWRITE = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [HDR_W-1:0] mem [SLOTS];
    logic [HDR_W-1:0] rd_q;

    logic [3:0]          state_reg, state_next;
    logic [LEN_W-1:0]    rover_reg, rover_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic                e0_written_reg;
    logic                rd_e0_reg;
    logic                grant_reg, grant_next;
    pool_op_t            op_reg, op_next;
    logic [POS_W-1:0]    at_reg, at_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    sum_reg, sum_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              re, we;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [HDR_W-1:0]  wdata;

    logic             hdr_used;
    logic [LEN_W-1:0] hdr_len;
    logic [CMP_W-1:0] at_c, len_c, need_c, idx_c, anxt, fnxt;
    logic [LEN_W-1:0] step;
    logic             fit, split;
    logic [LEN_W-1:0] merged;

    // Header memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_q <= mem[raddr];
        end
    end

    // Entry 0 reads as one free block of the whole pool until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_written_reg <= 1'b0;
            rd_e0_reg      <= 1'b0;
        end
        else
        begin
            if (we && (waddr == '0))
            begin
                e0_written_reg <= 1'b1;
            end
            if (re)
            begin
                rd_e0_reg <= (raddr == '0) && !e0_written_reg;
            end
        end
    end

    assign hdr_used = rd_e0_reg ? 1'b0 : rd_q[HDR_W-1];
    assign hdr_len  = rd_e0_reg ? FULL_LEN : rd_q[LEN_W-1:0];

    // Shared compare/add unit
    assign at_c   = CMP_W'(at_reg);
    assign len_c  = CMP_W'(hdr_len);
    assign need_c = CMP_W'(op_reg.need);
    assign idx_c  = CMP_W'(op_reg.idx);
    assign anxt   = at_c + need_c;
    assign fnxt   = idx_c + len_c;
    assign step   = (hdr_len != '0) ? hdr_len : LEN_W'(1);
    assign fit    = !hdr_used && (len_c >= need_c) && (need_c <= SLOTS_C - at_c);
    assign split  = (anxt < SLOTS_C) && (len_c != need_c);
    assign merged = (CMP_W'(sum_reg) > SLOTS_C) ? FULL_LEN : LEN_W'(sum_reg);

    always_comb
    begin
        state_next  = state_reg;
        rover_next  = rover_reg;
        count_next  = count_reg;
        grant_next  = grant_reg;
        op_next     = op_reg;
        at_next     = at_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        re          = 1'b0;
        raddr       = '0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    grant_next = 1'b0;
                    at_next    = POS_W'(rover_reg);
                    state_next = (op.cmd == CMD_ALLOC) ? S_AREAD : S_FREAD;
                end
            end

            S_AREAD:
            begin
                if (at_c >= SLOTS_C)
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = at_reg[ADDR_W-1:0];
                    state_next = S_AEVAL;
                end
            end

            S_AEVAL:
            begin
                if (fit)
                begin
                    we          = 1'b1;
                    waddr       = at_reg[ADDR_W-1:0];
                    wdata       = {1'b1, LEN_W'(op_reg.need)};
                    rover_next  = LEN_W'(anxt);
                    count_next  = count_reg + LEN_W'(op_reg.need);
                    len_next    = hdr_len - LEN_W'(op_reg.need);
                    grant_next  = 1'b1;
                    status_next = ST_OK;
                    state_next  = split ? S_ASPLIT : S_DONE;
                end
                else
                begin
                    at_next    = at_reg + POS_W'(step);
                    state_next = S_AREAD;
                end
            end

            S_ASPLIT:
            begin
                // Rover already points just past the new block
                we         = 1'b1;
                waddr      = rover_reg[ADDR_W-1:0];
                wdata      = {1'b0, len_reg};
                state_next = S_DONE;
            end

            S_FREAD:
            begin
                if (idx_c >= SLOTS_C)
                begin
                    status_next = ST_NOTUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = op_reg.idx[ADDR_W-1:0];
                    state_next = S_FEVAL;
                end
            end

            S_FEVAL:
            begin
                if (!hdr_used)
                begin
                    status_next = ST_NOTUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    len_next = hdr_len;
                    if (fnxt < SLOTS_C)
                    begin
                        re         = 1'b1;
                        raddr      = fnxt[ADDR_W-1:0];
                        state_next = S_FNEXT;
                    end
                    else
                    begin
                        sum_next   = POS_W'(hdr_len);
                        state_next = S_FWRITE;
                    end
                end
            end

            S_FNEXT:
            begin
                sum_next   = POS_W'(len_reg) + (hdr_used ? '0 : POS_W'(hdr_len));
                state_next = S_FWRITE;
            end

            S_FWRITE:
            begin
                we    = 1'b1;
                waddr = op_reg.idx[ADDR_W-1:0];
                wdata = {1'b0, merged};
                if (CMP_W'(rover_reg) > idx_c)
                begin
                    rover_next = LEN_W'(op_reg.idx);
                end
                count_next  = (count_reg >= len_reg) ? (count_reg - len_reg) : '0;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rover_reg <= '0;
            count_reg <= '0;
            grant_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rover_reg <= rover_next;
            count_reg <= count_next;
            grant_reg <= grant_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        at_reg     <= at_next;
        len_reg    <= len_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
    end

    assign res.done   = (state_reg == S_DONE);
    assign res.grant  = grant_reg;
    assign res.status = status_reg;
    assign res.index  = grant_reg ? GIDX_W'(at_reg) : '0;
    assign res.slots  = grant_reg ? GSLOTS_W'(op_reg.need) : '0;
    assign count      = count_reg;

endmodule

`default_nettype wire

// ===== design/two_pool_chunk_allocator.sv =====
// Top level of the two-pool chunk allocator: command intake, pool dispatch, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: cmd selects
//   allocate or free; request_bytes sizes an allocate, free_pool/free_index
//   name the block for a free. Requests of up to three small slots of bytes
//   go to the small pool, all others to the large pool.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   command: status, the granted pool/index/slots (zero unless granted) and
//   the in-use slot counts of both pools after the command.
//   Sequence: an allocate reads and compares each block header from the
//   rover on, writes the free tail on a split, then waits in the done
//   state. A free runs range check, header read, next-header read and
//   write. One command at a time: the next beat is taken once the result
//   is registered.
//   Reset: rovers and counts clear, and each pool's first header reads as
//   one free block spanning the pool; no clearing pass is needed.
//   Stall: a finished result sits in the output register until taken; the
//   next command is accepted meanwhile, and its result waits in the pool.
`timescale 1ns / 1ps
`default_nettype none

module two_pool_chunk_allocator
    import tpca_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   cmd,
    input  wire logic [BYTES_W-1:0]     request_bytes,
    input  wire logic                   free_pool,
    input  wire logic [FIDX_W-1:0]      free_index,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [STATUS_W-1:0]         status,
    output logic                        granted_pool,
    output logic [GIDX_W-1:0]           granted_index,
    output logic [GSLOTS_W-1:0]         granted_slots,
    output logic [SMALL_LEN_W-1:0]      small_in_use,
    output logic [LARGE_LEN_W-1:0]      large_in_use
);

    logic              req_pool;
    logic [NEED_W-1:0] req_need;

    pool_op_t  op;
    pool_res_t small_res, large_res, sel_res;
    logic [SMALL_LEN_W-1:0] small_count;
    logic [LARGE_LEN_W-1:0] large_count;

    logic accept, target_pool, move;
    logic busy_reg, busy_next;
    logic pool_sel_reg, pool_sel_next;
    logic out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0]    status_reg;
    logic                   gpool_reg;
    logic [GIDX_W-1:0]      gidx_reg;
    logic [GSLOTS_W-1:0]    gslots_reg;
    logic [SMALL_LEN_W-1:0] small_use_reg;
    logic [LARGE_LEN_W-1:0] large_use_reg;

    // Size the request and pick its pool
    tpca_need u_need
    (
        .request_bytes (request_bytes),
        .pool          (req_pool),
        .need          (req_need)
    );

    // Take a beat whenever no command is in flight
    assign in_ready    = !busy_reg;
    assign accept      = in_valid && in_ready;
    assign target_pool = (cmd == CMD_FREE) ? free_pool : req_pool;

    assign op.cmd  = cmd;
    assign op.need = req_need;
    assign op.idx  = free_index;

    tpca_pool #(.SLOTS(SMALL_SLOTS)) u_small
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (target_pool == POOL_SMALL)),
        .op    (op),
        .ack   (move && (pool_sel_reg == POOL_SMALL)),
        .res   (small_res),
        .count (small_count)
    );

    tpca_pool #(.SLOTS(LARGE_SLOTS)) u_large
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (target_pool == POOL_LARGE)),
        .op    (op),
        .ack   (move && (pool_sel_reg == POOL_LARGE)),
        .res   (large_res),
        .count (large_count)
    );

    assign sel_res = (pool_sel_reg == POOL_LARGE) ? large_res : small_res;

    // Advance a finished result into the output register once it is free
    assign move = busy_reg && sel_res.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        busy_next      = busy_reg;
        pool_sel_next  = pool_sel_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next     = 1'b1;
            pool_sel_next = target_pool;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pool_sel_reg  <= POOL_SMALL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pool_sel_reg  <= pool_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold until the next move
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            status_reg    <= sel_res.status;
            gpool_reg     <= sel_res.grant ? pool_sel_reg : POOL_SMALL;
            gidx_reg      <= sel_res.index;
            gslots_reg    <= sel_res.slots;
            small_use_reg <= small_count;
            large_use_reg <= large_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_pool  = gpool_reg;
    assign granted_index = gidx_reg;
    assign granted_slots = gslots_reg;
    assign small_in_use  = small_use_reg;
    assign large_in_use  = large_use_reg;

endmodule

`default_nettype wire

// ===== bench/two_pool_chunk_allocator_tb.sv =====
// Self-checking testbench for the two-pool chunk allocator: directed and random command traffic.
`timescale 1ns / 1ps

module two_pool_chunk_allocator_tb;
    import tpca_pkg::*;

    // Hang guard: the limit covers a walk over every small header, plus the
    // longest sender gap and receiver stall, with a wide margin.
    localparam int unsigned CYCLE_LIMIT  = 12_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned MAX_GAP      = 40;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned PHASE_ITEMS  = 320;

    // One result beat as the allocator returns it; field order matches the ports.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   pool;
        logic [GIDX_W-1:0]      index;
        logic [GSLOTS_W-1:0]    slots;
        logic [SMALL_LEN_W-1:0] small_used;
        logic [LARGE_LEN_W-1:0] large_used;
    } grant_result_t;

    // A block that the shadow pools currently hold as allocated.
    typedef struct {
        logic        pool;
        int unsigned index;
    } live_block_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   cmd = CMD_ALLOC;
    logic [BYTES_W-1:0]     request_bytes = '0;
    logic                   free_pool = POOL_SMALL;
    logic [FIDX_W-1:0]      free_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic                   granted_pool;
    logic [GIDX_W-1:0]      granted_index;
    logic [GSLOTS_W-1:0]    granted_slots;
    logic [SMALL_LEN_W-1:0] small_in_use;
    logic [LARGE_LEN_W-1:0] large_in_use;

    // Shadow copy of both pools. Large pool uses the first LARGE_SLOTS entries.
    bit          hdr_used [2][SMALL_SLOTS];
    int unsigned hdr_len  [2][SMALL_SLOTS];
    bit          hdr_seen [2][SMALL_SLOTS];
    int unsigned rover      [2];
    int unsigned used_slots [2];

    grant_result_t pending_grants [$];
    live_block_t   live_blocks [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    two_pool_chunk_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .free_pool     (free_pool),
        .free_index    (free_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_pool  (granted_pool),
        .granted_index (granted_index),
        .granted_slots (granted_slots),
        .small_in_use  (small_in_use),
        .large_in_use  (large_in_use)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hang guard: end the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: drop ready in recv_stall_pct cycles out of a hundred.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic int unsigned pool_size(input logic p);
        return (p == POOL_SMALL) ? SMALL_SLOTS : LARGE_SLOTS;
    endfunction

    // Bring the shadow pools to their post-reset shape: one free block per pool.
    function automatic void reset_pools();
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < SMALL_SLOTS; i++)
            begin
                hdr_used[p][i] = 1'b0;
                hdr_len[p][i]  = 0;
                hdr_seen[p][i] = 1'b0;
            end
            hdr_len[p][0]  = pool_size(p[0]);
            hdr_seen[p][0] = 1'b1;
            rover[p]       = 0;
            used_slots[p]  = 0;
        end
    endfunction

    // Next-fit walk from the rover, no wrap. Split the first fitting free block.
    function automatic bit carve_block(input logic p, input int unsigned need,
                                       output int unsigned where);
        int unsigned slots;
        int unsigned at;
        int unsigned len;
        slots = pool_size(p);
        at    = rover[p];
        where = 0;
        while (at < slots)
        begin
            len = hdr_len[p][at];
            if (!hdr_used[p][at] && len >= need && need <= slots - at)
            begin
                // Leave the tail as a free block unless the fit is exact.
                if (at + need < slots && len != need)
                begin
                    hdr_used[p][at + need] = 1'b0;
                    hdr_len[p][at + need]  = len - need;
                    hdr_seen[p][at + need] = 1'b1;
                end
                hdr_used[p][at] = 1'b1;
                hdr_len[p][at]  = need;
                rover[p]        = at + need;
                used_slots[p]  += need;
                where           = at;
                return 1'b1;
            end
            // Step over a zero-length header by one slot.
            at += (len != 0) ? len : 1;
        end
        return 1'b0;
    endfunction

    // Release a used block, absorb the following block if it is free.
    function automatic logic [STATUS_W-1:0] release_block(input logic p,
                                                          input int unsigned idx);
        int unsigned slots;
        int unsigned len;
        int unsigned nxt;
        int unsigned merged;
        slots = pool_size(p);
        if (idx >= slots || !hdr_used[p][idx])
            return ST_NOTUSED;
        len = hdr_len[p][idx];
        if (rover[p] > idx)
            rover[p] = idx;
        merged = len;
        nxt    = idx + len;
        if (nxt < slots && !hdr_used[p][nxt])
            merged += hdr_len[p][nxt];
        if (merged > slots)
            merged = slots;
        used_slots[p]   = (used_slots[p] >= len) ? used_slots[p] - len : 0;
        hdr_used[p][idx] = 1'b0;
        hdr_len[p][idx]  = merged;
        return ST_OK;
    endfunction

    // Work out the result beat of one command and advance the shadow pools.
    function automatic grant_result_t predict_grant(input logic c,
                                                    input logic [BYTES_W-1:0] bytes,
                                                    input logic fp,
                                                    input logic [FIDX_W-1:0] fi);
        grant_result_t res;
        int unsigned   need;
        int unsigned   where;
        logic          p;
        res = '0;
        if (c == CMD_ALLOC)
        begin
            if (32'(bytes) > SMALL_LIMIT)
            begin
                p    = POOL_LARGE;
                need = (32'(bytes) + 4) / LARGE_SLOT_BYTES + 1;
            end
            else
            begin
                p    = POOL_SMALL;
                need = (32'(bytes) + 4) / SMALL_SLOT_BYTES + 1;
            end
            if (carve_block(p, need, where))
            begin
                res.status = ST_OK;
                res.pool   = p;
                res.index  = GIDX_W'(where);
                res.slots  = GSLOTS_W'(need);
            end
            else
                res.status = ST_NOSPACE;
        end
        else
            res.status = release_block(fp, 32'(fi));
        res.small_used = SMALL_LEN_W'(used_slots[POOL_SMALL]);
        res.large_used = LARGE_LEN_W'(used_slots[POOL_LARGE]);
        return res;
    endfunction

    // Send one command beat. Hold valid across back-to-back beats; insert a
    // random idle gap first. Queue the expected result once the beat is taken.
    task automatic issue_command(input logic c, input logic [BYTES_W-1:0] bytes,
                                 input logic fp, input logic [FIDX_W-1:0] fi);
        grant_result_t exp_res;
        live_block_t   blk;
        int unsigned   gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        exp_res = predict_grant(c, bytes, fp, fi);
        // Keep the list of allocated blocks in step for later frees.
        if (exp_res.status == ST_OK && c == CMD_ALLOC)
        begin
            blk.pool  = exp_res.pool;
            blk.index = exp_res.index;
            live_blocks.push_back(blk);
        end
        else if (exp_res.status == ST_OK)
        begin
            for (int k = 0; k < live_blocks.size(); k++)
            begin
                if (live_blocks[k].pool == fp && live_blocks[k].index == fi)
                begin
                    live_blocks.delete(k);
                    break;
                end
            end
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        request_bytes <= bytes;
        free_pool     <= fp;
        free_index    <= fi;
        do
            @(posedge clk);
        while (!in_ready);
        pending_grants.push_back(exp_res);
    endtask

    // Check every accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        grant_result_t got;
        grant_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, granted_pool, granted_index, granted_slots,
                   small_in_use, large_in_use};
            if (pending_grants.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: status=%0d pool=%0d index=%0d",
                             got.status, got.pool, got.index);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.status !== want.status || got.pool !== want.pool ||
                    got.index !== want.index || got.slots !== want.slots ||
                    got.small_used !== want.small_used ||
                    got.large_used !== want.large_used)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("result mismatch");
                        $display("expected st=%0d pool=%0d idx=%0d slots=%0d small=%0d large=%0d",
                                 want.status, want.pool, want.index, want.slots,
                                 want.small_used, want.large_used);
                        $display("actual   st=%0d pool=%0d idx=%0d slots=%0d small=%0d large=%0d",
                                 got.status, got.pool, got.index, got.slots,
                                 got.small_used, got.large_used);
                    end
                end
            end
        end
    end

    // Size boundaries of both pools, plus allocations that split and frees that merge.
    task automatic test_size_classes();
        issue_command(CMD_ALLOC, 16'd0, POOL_SMALL, '0);
        issue_command(CMD_ALLOC, 16'd27, POOL_LARGE, '1);
        issue_command(CMD_ALLOC, 16'd28, POOL_SMALL, '0);
        issue_command(CMD_ALLOC, 16'(SMALL_LIMIT), POOL_LARGE, '1);
        issue_command(CMD_ALLOC, 16'(SMALL_LIMIT + 1), POOL_SMALL, '0);
        issue_command(CMD_ALLOC, 16'hFFFF, POOL_LARGE, '1);
        issue_command(CMD_FREE, 16'hFFFF, POOL_SMALL, 10'd2);
        issue_command(CMD_FREE, 16'd0, POOL_SMALL, 10'd2);
        issue_command(CMD_FREE, 16'hA5A5, POOL_SMALL, 10'd0);
        issue_command(CMD_FREE, 16'h5A5A, POOL_SMALL, 10'd1);
        issue_command(CMD_FREE, 16'd0, POOL_SMALL, 10'd4);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd0);
    endtask

    // Frees that must be refused: beyond the large pool, or of a free block.
    task automatic test_free_errors();
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd1023);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'(LARGE_SLOTS));
        issue_command(CMD_FREE, 16'd0, POOL_SMALL, 10'd0);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd0);
    endtask

    // Fill the large pool in one grant so the rover sits at the pool end,
    // then show that a free lowers it again.
    task automatic test_large_rover_end();
        issue_command(CMD_ALLOC, 16'd65276, POOL_SMALL, '0);
        issue_command(CMD_ALLOC, 16'd200, POOL_SMALL, '0);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd0);
        issue_command(CMD_ALLOC, 16'd65531, POOL_SMALL, '0);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd0);
        issue_command(CMD_ALLOC, 16'd97, POOL_SMALL, '0);
        issue_command(CMD_FREE, 16'd0, POOL_LARGE, 10'd0);
    endtask

    // Mostly well-formed alloc/free traffic with random sizes; the rest is
    // noise: frees of arbitrary known headers or out-of-range slots, and
    // requests of any size. live_cap bounds how fragmented the pools get.
    task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned live_cap);
        int unsigned  pick;
        int unsigned  free_share;
        int unsigned  k;
        logic         p;
        logic [9:0]   fi;
        logic [15:0]  bytes;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
        begin
            pick       = $urandom_range(0, 99);
            free_share = (live_blocks.size() > live_cap) ? 60 : 35;
            if (pick < free_share && live_blocks.size() != 0)
            begin
                k = $urandom_range(0, live_blocks.size() - 1);
                issue_command(CMD_FREE, 16'($urandom), live_blocks[k].pool,
                              10'(live_blocks[k].index));
            end
            else if (pick < 92)
            begin
                if ($urandom_range(0, 99) < 60)
                    bytes = 16'($urandom_range(0, SMALL_LIMIT));
                else if ($urandom_range(0, 99) < 75)
                    bytes = 16'($urandom_range(SMALL_LIMIT + 1, 4095));
                else
                    bytes = 16'($urandom_range(SMALL_LIMIT + 1, 65535));
                issue_command(CMD_ALLOC, bytes, 1'($urandom), 10'($urandom));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                // Never name a slot whose header was never written.
                p  = 1'($urandom);
                fi = 10'($urandom);
                if (32'(fi) < pool_size(p) && !hdr_seen[p][fi])
                    fi = '0;
                issue_command(CMD_FREE, 16'($urandom), p, fi);
            end
            else
                issue_command(CMD_ALLOC, 16'($urandom), 1'($urandom), 10'($urandom));
        end
    endtask

    initial
    begin
        reset_pools();
        // Hold reset, then release it once for the whole run.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_classes();
        test_free_errors();
        test_large_rover_end();

        // Idle phases: none, sender gaps, receiver stalls, then light gaps on
        // both sides with the pools allowed to fragment further.
        test_random_traffic(PHASE_ITEMS, 0, 0, 48);
        test_random_traffic(PHASE_ITEMS, 74, 0, 48);
        test_random_traffic(PHASE_ITEMS, 0, 74, 48);
        test_random_traffic(PHASE_ITEMS, 12, 12, 160);

        // Drop valid after the last beat, drain, then watch for stray beats.
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpca_pkg.sv
design/tpca_need.sv
design/tpca_pool.sv
design/two_pool_chunk_allocator.sv
bench/two_pool_chunk_allocator_tb.sv
